>>> design/hdlf_pkg.sv
// Package for the hex dump line formatter.
// Holds the item types, the sequencer states, character codes and helper functions.
// It depends on nothing else.
package hdlf_pkg;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEX_HI,
      ST_HEX_LO,
      ST_SPACE,
      ST_SEMI,
      ST_GAP,
      ST_COMMENT,
      ST_NEWLINE
   } state_type;

   localparam logic       CMD_DATA  = 1'b0;
   localparam logic       CMD_FLUSH = 1'b1;

   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_TILDE   = 8'd126;
   localparam logic [7:0] CHAR_SEMI    = 8'd59;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_QMARK   = 8'd63;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;

   localparam logic [5:0] BPL_RESET = 6'd20;
   localparam int         REG_BYTES_PER_LINE = 0;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v <= 4'd9) begin
         r = CHAR_ZERO + {4'd0, v};
      end else begin
         r = CHAR_UPPER_A + {4'd0, v} - 8'd10;
      end
      return r;
   endfunction

   function automatic logic [7:0] printable(input logic [7:0] c);
      logic [7:0] r;
      if (c < CHAR_SPACE || c > CHAR_TILDE) begin
         r = CHAR_QMARK;
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

>>> design/hdlf_csr.sv
// Configuration register block of the hex dump line formatter.
// Holds bytes_per_line behind an APB-style port; uses hdlf_pkg.
module hdlf_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [5:0]  bytes_per_line
);

   logic [5:0] bpl_ff;
   logic [5:0] bpl_in;
   logic       index;
   logic       hit;

   assign index  = paddr[2];
   assign hit    = (index == 1'(hdlf_pkg::REG_BYTES_PER_LINE));
   assign pready = 1'b1;

   always_comb begin
      bpl_in = bpl_ff;
      if (psel && penable && pwrite && hit) begin
         bpl_in = pwdata[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpl_ff <= hdlf_pkg::BPL_RESET;
      end else begin
         bpl_ff <= bpl_in;
      end
   end

   assign prdata         = hit ? {26'd0, bpl_ff} : 32'd0;
   assign bytes_per_line = bpl_ff;

endmodule

>>> design/hdlf_line_mem.sv
// Line store of the hex dump line formatter: one write port, one registered read port.
// Holds the printable form of the bytes of the current line; uses no package items.
module hdlf_line_mem #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/hex_dump_line_formatter.sv
// Hex dump line formatter: turns bytes into hex dump text, one character per result item.
// A data item gives three characters: two hex digits and a space. One that ends a
// line adds a semicolon, a space, the n stored bytes and a newline; a flush gives
// only these. A new item is taken only in the idle state. Within an item, one character
// leaves per cycle from the output register while rsp_ready is high. Reset is synchronous:
// the line is emptied and bytes_per_line returns to 20; the line store itself is not cleared.
module hex_dump_line_formatter #(
   parameter int MAX_LINE_BYTES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hdlf_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hdlf_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int ADDR_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
   localparam int FILL_W = $clog2(MAX_LINE_BYTES + 1);
   localparam int CMP_W  = (FILL_W > 7) ? FILL_W : 7;

   hdlf_pkg::state_type state_ff, state_in;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [7:0]        byte_ff, byte_in;
   logic              comment_ff, comment_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hdlf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [5:0]        bytes_per_line;
   logic [CMP_W-1:0]  limit;
   logic [FILL_W-1:0] fill_next;
   logic              accept;
   logic              out_free;
   logic              emit;
   hdlf_pkg::rsp_type emit_data;
   logic              wr_en;
   logic              rd_en;
   logic [FILL_W-1:0] rd_index;
   logic [7:0]        rd_data;

   hdlf_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .bytes_per_line (bytes_per_line)
   );

   hdlf_line_mem #(
      .DEPTH  (MAX_LINE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (hdlf_pkg::printable(req_data.data_byte)),
      .rd_en   (rd_en),
      .rd_addr (rd_index[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      limit = {{(CMP_W-6){1'b0}}, bytes_per_line};
      if (limit == '0) begin
         limit = CMP_W'(1);
      end
      if (limit > CMP_W'(MAX_LINE_BYTES)) begin
         limit = CMP_W'(MAX_LINE_BYTES);
      end
   end

   assign req_ready = (state_ff == hdlf_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign wr_en     = accept && (req_data.cmd == hdlf_pkg::CMD_DATA) &&
                      (fill_ff < FILL_W'(MAX_LINE_BYTES));
   assign fill_next = wr_en ? fill_ff + FILL_W'(1) : fill_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hdlf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.cmd == hdlf_pkg::CMD_FLUSH) ?
                          hdlf_pkg::ST_SEMI : hdlf_pkg::ST_HEX_HI;
            end
         end
         hdlf_pkg::ST_HEX_HI: begin
            if (out_free) state_in = hdlf_pkg::ST_HEX_LO;
         end
         hdlf_pkg::ST_HEX_LO: begin
            if (out_free) state_in = hdlf_pkg::ST_SPACE;
         end
         hdlf_pkg::ST_SPACE: begin
            if (out_free) state_in = comment_ff ? hdlf_pkg::ST_SEMI : hdlf_pkg::ST_IDLE;
         end
         hdlf_pkg::ST_SEMI: begin
            if (out_free) state_in = hdlf_pkg::ST_GAP;
         end
         hdlf_pkg::ST_GAP: begin
            if (out_free) begin
               state_in = (fill_ff == '0) ? hdlf_pkg::ST_NEWLINE : hdlf_pkg::ST_COMMENT;
            end
         end
         hdlf_pkg::ST_COMMENT: begin
            if (out_free && (idx_ff + FILL_W'(1) == fill_ff)) begin
               state_in = hdlf_pkg::ST_NEWLINE;
            end
         end
         hdlf_pkg::ST_NEWLINE: begin
            if (out_free) state_in = hdlf_pkg::ST_IDLE;
         end
         default: state_in = hdlf_pkg::ST_IDLE;
      endcase
   end

   // Outputs of each state.
   always_comb begin
      emit      = 1'b0;
      emit_data = '{out_char: hdlf_pkg::CHAR_SPACE, last_char: 1'b0};
      rd_en     = 1'b0;
      rd_index  = '0;
      idx_in    = idx_ff;
      case (state_ff)
         hdlf_pkg::ST_IDLE: begin
            emit = 1'b0;
         end
         hdlf_pkg::ST_HEX_HI: begin
            emit               = 1'b1;
            emit_data.out_char = hdlf_pkg::hex_digit(byte_ff[7:4]);
         end
         hdlf_pkg::ST_HEX_LO: begin
            emit               = 1'b1;
            emit_data.out_char = hdlf_pkg::hex_digit(byte_ff[3:0]);
         end
         hdlf_pkg::ST_SPACE: begin
            emit                = 1'b1;
            emit_data.last_char = !comment_ff;
         end
         hdlf_pkg::ST_SEMI: begin
            emit               = 1'b1;
            emit_data.out_char = hdlf_pkg::CHAR_SEMI;
         end
         hdlf_pkg::ST_GAP: begin
            emit     = 1'b1;
            rd_en    = out_free && (fill_ff != '0);
            rd_index = '0;
            if (out_free) idx_in = '0;
         end
         hdlf_pkg::ST_COMMENT: begin
            emit               = 1'b1;
            emit_data.out_char = rd_data;
            rd_index           = idx_ff + FILL_W'(1);
            rd_en              = out_free && (rd_index < fill_ff);
            if (out_free) idx_in = rd_index;
         end
         hdlf_pkg::ST_NEWLINE: begin
            emit                = 1'b1;
            emit_data.out_char  = hdlf_pkg::CHAR_NEWLINE;
            emit_data.last_char = 1'b1;
         end
         default: emit = 1'b0;
      endcase
   end

   always_comb begin
      byte_in    = byte_ff;
      comment_in = comment_ff;
      fill_in    = fill_next;
      if (accept) begin
         byte_in    = req_data.data_byte;
         comment_in = (req_data.cmd == hdlf_pkg::CMD_FLUSH) ||
                      ({{(CMP_W-FILL_W){1'b0}}, fill_next} >= limit);
      end
      if ((state_ff == hdlf_pkg::ST_NEWLINE) && out_free) begin
         fill_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hdlf_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      byte_ff     <= byte_in;
      comment_ff  <= comment_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> dv/tb.sv
// Self-checking testbench for the hex dump line formatter, with its own model of the text.
// Depends on the package hdlf_pkg and on the module hex_dump_line_formatter.
`timescale 1ns / 100ps

module tb;

   localparam int LINE_MAX       = 32;
   localparam int REG_UNMAPPED   = 1;
   localparam int IDLE_LIMIT     = 4000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 40;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   hdlf_pkg::req_type   req_data;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   hdlf_pkg::rsp_type   rsp_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [2:0]          paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   hdlf_pkg::rsp_type   expected_chars[$];
   logic [7:0]          line_chars[LINE_MAX];
   int                  line_fill;
   logic [5:0]          bytes_per_line;
   int                  errors = 0;
   bit                  gap_enable;
   bit                  stall_enable;
   int                  stall_left = 0;
   int                  stall_pick;

   hex_dump_line_formatter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] nibble_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return hdlf_pkg::CHAR_ZERO + 8'(v);
      end
      return hdlf_pkg::CHAR_UPPER_A + 8'(v - 4'd10);
   endfunction

   function automatic logic [7:0] shown_char(input logic [7:0] c);
      return (c >= hdlf_pkg::CHAR_SPACE && c <= hdlf_pkg::CHAR_TILDE) ?
             c : hdlf_pkg::CHAR_QMARK;
   endfunction

   function automatic void push_char(input logic [7:0] c);
      hdlf_pkg::rsp_type r;
      r.out_char  = c;
      r.last_char = 1'b0;
      expected_chars.insert(expected_chars.size(), r);
   endfunction

   function automatic void push_comment();
      push_char(hdlf_pkg::CHAR_SEMI);
      push_char(hdlf_pkg::CHAR_SPACE);
      for (int i = 0; i < line_fill; i++) begin
         push_char(line_chars[i]);
      end
      push_char(hdlf_pkg::CHAR_NEWLINE);
      line_fill = 0;
   endfunction

   // Works out the characters that one item produces and queues them in order.
   function automatic void predict_dump_text(input hdlf_pkg::req_type item);
      int limit;
      limit = (bytes_per_line == 6'd0) ? 1 :
              (int'(bytes_per_line) > LINE_MAX) ? LINE_MAX : int'(bytes_per_line);
      if (item.cmd == hdlf_pkg::CMD_DATA) begin
         push_char(nibble_char(item.data_byte[7:4]));
         push_char(nibble_char(item.data_byte[3:0]));
         push_char(hdlf_pkg::CHAR_SPACE);
         if (line_fill < LINE_MAX) begin
            line_chars[line_fill] = shown_char(item.data_byte);
            line_fill++;
         end
         if (line_fill >= limit) begin
            push_comment();
         end
      end else begin
         push_comment();
      end
      expected_chars[expected_chars.size() - 1].last_char = 1'b1;
   endfunction

   function automatic hdlf_pkg::req_type data_item(input logic [7:0] b);
      hdlf_pkg::req_type r;
      r.cmd       = hdlf_pkg::CMD_DATA;
      r.data_byte = b;
      return r;
   endfunction

   function automatic hdlf_pkg::req_type flush_item();
      hdlf_pkg::req_type r;
      r.cmd       = hdlf_pkg::CMD_FLUSH;
      r.data_byte = 8'($urandom);
      return r;
   endfunction

   task automatic send_item(input hdlf_pkg::req_type item);
      int gap;
      gap = gap_enable ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      predict_dump_text(item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Lowers valid and waits until every expected character has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input int index, input logic [31:0] value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(4 * index);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == hdlf_pkg::REG_BYTES_PER_LINE) begin
         bytes_per_line = value[5:0];
      end
      @(posedge clock);
   endtask

   task automatic check_bytes_per_line();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= 3'(4 * hdlf_pkg::REG_BYTES_PER_LINE);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[5:0] !== bytes_per_line) begin
         $error("bytes_per_line: expected %0d, got %0d", bytes_per_line, prdata[5:0]);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_reset_value();
      check_bytes_per_line();
   endtask

   task automatic test_hex_and_printable();
      csr_write(hdlf_pkg::REG_BYTES_PER_LINE, 32'd4);
      send_item(data_item(8'h00));
      send_item(data_item(8'hFF));
      send_item(data_item(8'h1F));
      send_item(data_item(8'h20));
      send_item(data_item(8'h7E));
      send_item(data_item(8'h7F));
      send_item(data_item(8'h41));
      send_item(flush_item());
      drain();
   endtask

   task automatic test_flush_and_line_extremes();
      send_item(flush_item());
      csr_write(hdlf_pkg::REG_BYTES_PER_LINE, 32'd0);
      send_item(data_item(8'h9A));
      send_item(data_item(8'h5C));
      csr_write(hdlf_pkg::REG_BYTES_PER_LINE, 32'hFFFF_FFFF);
      check_bytes_per_line();
      send_item(data_item(8'hA5));
      send_item(data_item(8'h3C));
      send_item(flush_item());
      drain();
   endtask

   task automatic test_lowered_mid_line();
      csr_write(hdlf_pkg::REG_BYTES_PER_LINE, 32'd8);
      for (int i = 0; i < 5; i++) begin
         send_item(data_item(8'($urandom)));
      end
      csr_write(hdlf_pkg::REG_BYTES_PER_LINE, 32'd2);
      send_item(data_item(8'h6B));
      drain();
   endtask

   task automatic test_unmapped_register();
      csr_write(REG_UNMAPPED, 32'd5);
      check_bytes_per_line();
      send_item(data_item(8'h30));
      send_item(data_item(8'hC9));
      drain();
   endtask

   task automatic test_random_stream();
      logic [5:0] widths[12] = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd5, 6'd8, 6'd20, 6'd31,
                                 6'd32, 6'd33, 6'd63, 6'd16};
      logic [7:0] edges[6]   = '{8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'hFF};
      logic [5:0] width;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         width = (p == RANDOM_PHASES - 1) ? 6'($urandom) : widths[$urandom_range(0, 11)];
         csr_write(hdlf_pkg::REG_BYTES_PER_LINE,
                   {$urandom_range(0, 3) == 0 ? 26'($urandom) : 26'd0, width});
         gap_enable   = ($urandom_range(0, 3) != 0);
         stall_enable = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               send_item(flush_item());
            end else if ($urandom_range(0, 3) == 0) begin
               send_item(data_item(edges[$urandom_range(0, 5)]));
            end else begin
               send_item(data_item(8'($urandom)));
            end
         end
         if ($urandom_range(0, 1) == 0) begin
            send_item(flush_item());
         end
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (stall_enable) begin
            stall_pick = $urandom_range(0, 19);
            if (stall_pick > 0) begin
               stall_left <= stall_pick;
               rsp_ready  <= 1'b0;
            end
         end
      end else if (!rsp_ready) begin
         if (stall_left <= 1) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left <= stall_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected character %0d", rsp_data.out_char);
            errors++;
         end else begin
            if (rsp_data.out_char !== expected_chars[0].out_char) begin
               $error("out_char: expected %0d, got %0d",
                      expected_chars[0].out_char, rsp_data.out_char);
               errors++;
            end
            if (rsp_data.last_char !== expected_chars[0].last_char) begin
               $error("last_char: expected %0d, got %0d",
                      expected_chars[0].last_char, rsp_data.last_char);
               errors++;
            end
            void'(expected_chars.pop_front());
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (psel && penable)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      gap_enable     = 1'b1;
      stall_enable   = 1'b1;
      line_fill      = 0;
      bytes_per_line = hdlf_pkg::BPL_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_hex_and_printable();
      test_flush_and_line_extremes();
      test_lowered_mid_line();
      test_unmapped_register();
      test_random_stream();
      drain();
      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/hdlf_pkg.sv
design/hdlf_csr.sv
design/hdlf_line_mem.sv
design/hex_dump_line_formatter.sv
dv/tb.sv
